### hw/rtl/ssm_pkg.sv
package ssm_pkg;

	localparam int unsigned KEY_W     = 32;
	localparam int unsigned HASH_MULT = 13;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] value;
	} slot_t;

endpackage

### hw/rtl/sparse_swap_map.sv
// Swap-only sparse array over a bucketed hash table.
// Every array entry starts equal to its key. A command beat carries key_a and
// key_b and is taken on a rising edge with start high and busy low. Missing
// keys are inserted with value = key, the two stored values are exchanged and
// one result beat follows: done high for exactly one cycle with abs_difference
// = |value(a) - value(b)| and table_full. On a full bucket nothing is written,
// table_full is 1 and abs_difference is 0.
// The result beat follows the S_WRA step when both keys share a bucket or the table
// is full, otherwise the S_WRB step; busy is low in the done cycle, and a new
// command is taken only once the last one is done.
// The steps follow the bucket memory: one row read for each key, a compare step,
// then one row write step for each bucket touched.
// After reset busy stays high while a clearing pass invalidates one bucket row
// a cycle.
// The receiver cannot stall: done is not held beyond its cycle.
// NUM_BUCKETS must be a power of two; the bucket is the low bits of key * 13.
module sparse_swap_map #(
	parameter int unsigned NUM_BUCKETS = 1024,
	parameter int unsigned WAYS        = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] key_a,
	input  logic [31:0] key_b,
	output logic        done,
	output logic [31:0] abs_difference,
	output logic        table_full
);

	localparam int unsigned BW    = $clog2(NUM_BUCKETS);
	localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned KW    = ssm_pkg::KEY_W;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_RDB   = 6'b000100,
		S_CALC  = 6'b001000,
		S_WRA   = 6'b010000,
		S_WRB   = 6'b100000
	} state_t;

	typedef ssm_pkg::slot_t [WAYS-1:0] row_t;

	state_t state_q;
	logic [BW-1:0] clr_q;
	logic [KW-1:0] ka_q, kb_q, va_q, vb_q;
	logic [BW-1:0] bkt_a_q, bkt_b_q;
	logic [WAY_W-1:0] wa_q, wb_q;
	logic full_q;
	row_t row_a_q, rd_q;
	row_t mem [NUM_BUCKETS];

	logic rd_en, wr_en;
	logic [BW-1:0] rd_addr, wr_addr;
	row_t wr_row;

	logic done_q, full_out_q;
	logic [KW-1:0] diff_q;

	function automatic logic [BW-1:0] bucket_of(input logic [KW-1:0] k);
		logic [BW-1:0] lo;
		lo = k[BW-1:0];
		return BW'(lo * BW'(ssm_pkg::HASH_MULT));
	endfunction

	// way search for both keys
	logic same_key, same_bkt;
	logic hit_a, free_a, hit_b, free_b;
	logic [WAY_W-1:0] hit_way_a, free_way_a, hit_way_b, free_way_b;

	assign same_key = (ka_q == kb_q);
	assign same_bkt = (bkt_a_q == bkt_b_q);

	ssm_way_search #(.WAYS(WAYS), .WAY_W(WAY_W)) u_search_a (
		.row      (row_a_q),
		.key      (ka_q),
		.excl_en  (1'b0),
		.excl_way (wa_q),
		.hit      (hit_a),
		.hit_way  (hit_way_a),
		.free     (free_a),
		.free_way (free_way_a)
	);

	ssm_way_search #(.WAYS(WAYS), .WAY_W(WAY_W)) u_search_b (
		.row      (rd_q),
		.key      (kb_q),
		.excl_en  (same_bkt && !hit_a),
		.excl_way (free_way_a),
		.hit      (hit_b),
		.hit_way  (hit_way_b),
		.free     (free_b),
		.free_way (free_way_b)
	);

	logic [WAY_W-1:0] wa_d, wb_d;
	logic [KW-1:0] va_d, vb_d;
	logic full_d;

	always_comb begin
		wa_d   = hit_a ? hit_way_a : free_way_a;
		va_d   = hit_a ? row_a_q[hit_way_a].value : ka_q;
		wb_d   = same_key ? wa_d : (hit_b ? hit_way_b : free_way_b);
		vb_d   = same_key ? va_d : (hit_b ? rd_q[hit_way_b].value : kb_q);
		full_d = (!hit_a && !free_a) || (!same_key && !hit_b && !free_b);
	end

	// memory control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = bucket_of(key_a);
		wr_en   = 1'b0;
		wr_addr = bkt_a_q;
		wr_row  = row_a_q;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_row  = '0;
			end
			S_IDLE: begin
				rd_en = start;
			end
			S_RDB: begin
				rd_en   = 1'b1;
				rd_addr = bkt_b_q;
			end
			S_CALC: ;
			S_WRA: begin
				wr_en = !full_q;
				wr_row[wa_q] = '{valid: 1'b1, key: ka_q, value: vb_q};
				if (same_bkt) begin
					wr_row[wb_q] = '{valid: 1'b1, key: kb_q, value: va_q};
				end
			end
			S_WRB: begin
				wr_en   = 1'b1;
				wr_addr = bkt_b_q;
				wr_row  = rd_q;
				wr_row[wb_q] = '{valid: 1'b1, key: kb_q, value: va_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			ka_q    <= key_a;
			kb_q    <= key_b;
			bkt_a_q <= bucket_of(key_a);
			bkt_b_q <= bucket_of(key_b);
		end
		if (state_q == S_RDB) begin
			row_a_q <= rd_q;
		end
		if (state_q == S_CALC) begin
			wa_q   <= wa_d;
			wb_q   <= wb_d;
			va_q   <= va_d;
			vb_q   <= vb_d;
			full_q <= full_d;
		end
	end

	// sequencer and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			full_out_q <= 1'b0;
			diff_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(NUM_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_RDB;
					end
				end
				S_RDB:  state_q <= S_CALC;
				S_CALC: state_q <= S_WRA;
				S_WRA: begin
					diff_q     <= full_q ? '0 :
						((va_q >= vb_q) ? (va_q - vb_q) : (vb_q - va_q));
					full_out_q <= full_q;
					if (full_q || same_bkt) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WRB;
					end
				end
				S_WRB: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign abs_difference = diff_q;
	assign table_full     = full_out_q;

	a_done_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == S_WRA || $past(state_q) == S_WRB))
		else $error("result beat without a preceding write step");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && full_out_q) |-> (diff_q == '0))
		else $error("full bucket reported with non-zero difference");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_RDB || state_q == S_CALC) |-> !wr_en)
		else $error("memory written outside a write step");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRA && full_q) |-> !wr_en)
		else $error("table changed on a full bucket");

endmodule

### hw/rtl/ssm_way_search.sv
module ssm_way_search #(
	parameter int unsigned WAYS  = 4,
	parameter int unsigned WAY_W = 2
) (
	input  ssm_pkg::slot_t [WAYS-1:0]  row,
	input  logic [ssm_pkg::KEY_W-1:0]  key,
	input  logic                       excl_en,
	input  logic [WAY_W-1:0]           excl_way,
	output logic                       hit,
	output logic [WAY_W-1:0]           hit_way,
	output logic                       free,
	output logic [WAY_W-1:0]           free_way
);

	// lowest-numbered matching or free way wins
	always_comb begin
		hit      = 1'b0;
		hit_way  = '0;
		free     = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row[w].valid && row[w].key == key) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!row[w].valid && !(excl_en && excl_way == WAY_W'(w))) begin
				free     = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

endmodule
